FILE: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block refers to this package.
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int TAG_BITS    = 16;
  localparam int KEY_BITS    = 31;
  localparam int ACT_BITS    = 2;
  localparam int STATUS_BITS = 3;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_LISTED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_REM_HEAD,
    S_REM_SHIFT,
    S_LIST,
    S_EMIT
  } state_t;

  // read address source
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_TAIL,
    RD_DEC,
    RD_INC
  } rd_sel_t;

  // write address and data source
  typedef enum logic [1:0] {
    WR_UP,
    WR_DOWN,
    WR_NEW_UP,
    WR_NEW_HEAD
  } wr_sel_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic    ld_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_data;
    status_t emit_status;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic moves;
    logic cur_zero;
    logic cur_tail;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/spq_req_if.sv
// Request channel of the sorted priority queue: valid/ready plus one request word.
// Depends on spq_pkg for field widths.
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::ACT_BITS-1:0] action;
  logic [spq_pkg::KEY_BITS-1:0] key;
  logic [spq_pkg::TAG_BITS-1:0] tag;

  modport source (output valid, output action, output key, output tag, input ready);
  modport sink (input valid, input action, input key, input tag, output ready);
endinterface

FILE: hdl/spq_rsp_if.sv
// Response channel of the sorted priority queue: valid/ready plus one result word.
// Depends on spq_pkg for field widths.
interface spq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_BITS-1:0] status;
  logic [spq_pkg::KEY_BITS-1:0]    out_key;
  logic [spq_pkg::TAG_BITS-1:0]    out_tag;
  logic                            last;

  modport source (output valid, output status, output out_key, output out_tag,
                  output last, input ready);
  modport sink (input valid, input status, input out_key, input out_tag,
                input last, output ready);
endinterface

FILE: hdl/spq_dpath.sv
// Datapath of the sorted priority queue: entry memory, fill count, walk index,
// compare against the new key and the output word register. Depends on spq_pkg.
module spq_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::cmd_t                   cmd,
  output spq_pkg::stat_t                  stat,
  input  logic [spq_pkg::KEY_BITS-1:0]    key,
  input  logic [spq_pkg::TAG_BITS-1:0]    tag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spq_pkg::STATUS_BITS-1:0] out_status,
  output logic [spq_pkg::KEY_BITS-1:0]    out_key,
  output logic [spq_pkg::TAG_BITS-1:0]    out_tag,
  output logic                            out_last
);

  spq_pkg::entry_t                mem [spq_pkg::CAPACITY];
  spq_pkg::entry_t                rd_q;
  spq_pkg::entry_t                new_q;
  spq_pkg::entry_t                wr_data;
  logic [spq_pkg::CNT_W-1:0]      count;
  logic [spq_pkg::CNT_W-1:0]      cnt_m1;
  logic [spq_pkg::IDX_W-1:0]      cur;
  logic [spq_pkg::IDX_W-1:0]      rd_addr;
  logic [spq_pkg::IDX_W-1:0]      wr_addr;

  assign cnt_m1 = count - spq_pkg::CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      spq_pkg::RD_ZERO: rd_addr = '0;
      spq_pkg::RD_TAIL: rd_addr = cnt_m1[spq_pkg::IDX_W-1:0];
      spq_pkg::RD_DEC:  rd_addr = cur - spq_pkg::IDX_W'(1);
      spq_pkg::RD_INC:  rd_addr = cur + spq_pkg::IDX_W'(1);
      default:          rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      spq_pkg::WR_UP: begin
        wr_addr = cur + spq_pkg::IDX_W'(1);
        wr_data = rd_q;
      end
      spq_pkg::WR_DOWN: begin
        wr_addr = cur - spq_pkg::IDX_W'(1);
        wr_data = rd_q;
      end
      spq_pkg::WR_NEW_UP: begin
        wr_addr = cur + spq_pkg::IDX_W'(1);
        wr_data = new_q;
      end
      spq_pkg::WR_NEW_HEAD: begin
        wr_addr = '0;
        wr_data = new_q;
      end
      default: begin
        wr_addr = '0;
        wr_data = new_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      new_q.key <= key;
      new_q.tag <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cur   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + spq_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
      if (cmd.rd_en) begin
        cur <= rd_addr;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_last   <= cmd.emit_last;
      out_key    <= cmd.emit_data ? rd_q.key : '0;
      out_tag    <= cmd.emit_data ? rd_q.tag : '0;
    end
  end

  // head entry moves on a strictly larger key, any other entry on a key at least as large
  always_comb begin
    stat.count_zero = (count == '0);
    stat.count_full = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    stat.cur_zero   = (cur == '0);
    stat.cur_tail   = (spq_pkg::CNT_W'(cur) == cnt_m1);
    stat.moves      = (cur == '0) ? (new_q.key < rd_q.key) : (rd_q.key >= new_q.key);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: hdl/spq_ctrl.sv
// Controller of the sorted priority queue: decodes the request word and
// sequences the walks over the entry memory. Depends on spq_pkg.
module spq_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::ACT_BITS-1:0] action,
  input  spq_pkg::stat_t               stat,
  output spq_pkg::cmd_t                cmd
);

  spq_pkg::state_t  state;
  spq_pkg::state_t  state_next;
  spq_pkg::status_t code;
  spq_pkg::status_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
      code  <= spq_pkg::ST_INSERTED;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next      = state;
    code_next       = code;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.rd_sel      = spq_pkg::RD_ZERO;
    cmd.wr_sel      = spq_pkg::WR_UP;
    cmd.emit_status = code;

    unique case (state)
      spq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          unique case (action) inside
            spq_pkg::ACT_INSERT: begin
              if (stat.count_full) begin
                code_next  = spq_pkg::ST_FULL;
                state_next = spq_pkg::S_EMIT;
              end else if (stat.count_zero) begin
                state_next = spq_pkg::S_INS_HEAD;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = spq_pkg::RD_TAIL;
                state_next = spq_pkg::S_INS;
              end
            end
            spq_pkg::ACT_REMOVE, spq_pkg::ACT_LIST: begin
              if (stat.count_zero) begin
                code_next  = spq_pkg::ST_EMPTY;
                state_next = spq_pkg::S_EMIT;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = spq_pkg::RD_ZERO;
                state_next = (action == spq_pkg::ACT_REMOVE) ? spq_pkg::S_REM_HEAD
                                                             : spq_pkg::S_LIST;
              end
            end
            default: state_next = spq_pkg::S_IDLE;
          endcase
        end
      end

      // walk tail to head, shifting each entry flagged by stat.moves up by one
      spq_pkg::S_INS: begin
        cmd.wr_en = 1'b1;
        if (stat.moves) begin
          cmd.wr_sel = spq_pkg::WR_UP;
          if (stat.cur_zero) begin
            state_next = spq_pkg::S_INS_HEAD;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_DEC;
          end
        end else begin
          cmd.wr_sel  = spq_pkg::WR_NEW_UP;
          cmd.cnt_inc = 1'b1;
          code_next   = spq_pkg::ST_INSERTED;
          state_next  = spq_pkg::S_EMIT;
        end
      end

      spq_pkg::S_INS_HEAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = spq_pkg::WR_NEW_HEAD;
        cmd.cnt_inc = 1'b1;
        code_next   = spq_pkg::ST_INSERTED;
        state_next  = spq_pkg::S_EMIT;
      end

      spq_pkg::S_REM_HEAD: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_data   = 1'b1;
          cmd.emit_status = spq_pkg::ST_REMOVED;
          cmd.emit_last   = 1'b1;
          if (stat.cur_tail) begin
            cmd.cnt_dec = 1'b1;
            state_next  = spq_pkg::S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_INC;
            state_next = spq_pkg::S_REM_SHIFT;
          end
        end
      end

      // move each entry down by one, head to tail
      spq_pkg::S_REM_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = spq_pkg::WR_DOWN;
        if (stat.cur_tail) begin
          cmd.cnt_dec = 1'b1;
          state_next  = spq_pkg::S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_INC;
        end
      end

      spq_pkg::S_LIST: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_data   = 1'b1;
          cmd.emit_status = spq_pkg::ST_LISTED;
          cmd.emit_last   = stat.cur_tail;
          if (stat.cur_tail) begin
            state_next = spq_pkg::S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_INC;
          end
        end
      end

      spq_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = code;
          cmd.emit_last   = 1'b1;
          state_next      = spq_pkg::S_IDLE;
        end
      end

      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl and spq_dpath.
//
//   channel  direction  word                            handshake
//   req      in         action, key, tag                valid/ready
//   rsp      out        status, out_key, out_tag, last  valid/ready
//
// One request at a time; req.ready is high only between requests.
// Insert walks from the tail toward the head, one memory read per entry walked.
// Remove reads the head, then shifts each remaining entry down by one.
// List emits one word per cycle while rsp.ready stays high.
// A stalled rsp holds the walk; a pending word sits in the output register.
// Synchronous reset empties the queue; entry memory is not cleared.
module sorted_priority_queue (
  input logic     clk,
  input logic     rst,
  spq_req_if.sink req,
  spq_rsp_if.source rsp
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .action   (req.action),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .key        (req.key),
    .tag        (req.tag),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_key    (rsp.out_key),
    .out_tag    (rsp.out_tag),
    .out_last   (rsp.last)
  );

endmodule
